[design/hsc_pkg.sv]
// Shared types, constants and payload structs of the SECDED byte codec.
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int BLOCK_BYTES = 15;
  localparam int SLOT_W      = 4;
  localparam int POS_W       = 7;
  localparam int LEN_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int JOB_DEPTH   = 4;
  localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);

  localparam logic [SLOT_W-1:0] LAST_DATA_SLOT = SLOT_W'(BLOCK_BYTES - 1);
  localparam logic [SLOT_W-1:0] CHECK_SLOT     = SLOT_W'(BLOCK_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION     = 1'b0,
    REG_DECODE_LENGTH = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_PARITY    = 2'd2,
    ST_DOUBLE    = 2'd3
  } err_status_e;

  typedef enum logic {
    JOB_ENC = 1'b0,
    JOB_DEC = 1'b1
  } job_kind_e;

  typedef struct packed {
    logic [7:0] data_in;
    logic       end_of_stream;
  } hsc_in_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             is_check_byte;
    logic [1:0]       error_status;
    logic [POS_W-1:0] error_position;
    logic             last;
  } hsc_out_t;

  // One unit of work for the back end: an encoded byte with its padding and
  // check byte, or a decoded block held in one bank of the byte store.
  typedef struct packed {
    job_kind_e         kind;
    logic [7:0]        data;
    logic [SLOT_W-1:0] pad_cnt;
    logic              has_check;
    logic [7:0]        check;
    logic              bank;
    logic [SLOT_W-1:0] emit_cnt;
    err_status_e       status;
    logic [POS_W-1:0]  position;
    logic              flip_valid;
    logic [SLOT_W-1:0] flip_byte;
    logic [7:0]        flip_mask;
  } job_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [SLOT_W-1:0] idx;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

[design/secded_hamming_128_120_byte_codec.sv]
// Top level of the byte-stream extended Hamming SECDED (128,120) codec.
// Input is a queue write side: an item (data_in, end_of_stream) is taken at
// a clock edge with push high and full low. Results come from a queue read
// side: the oldest result sits on out_item_o while empty is low and leaves
// at an edge with pop high. Configuration: cfg_we_i writes cfg_data_i into
// register cfg_idx_i (0 direction, 1 decode_length) with no wait.
// Encode: each byte passes through; every 15th byte, or end of stream after
// zero padding, is followed by the check byte. Decode: 16 bytes per block
// are taken in, then 15 corrected bytes go out, cut at decode_length.
// The first result of an item reaches the ports through the job queue and
// the back end's output register. The back end issues one result per cycle
// from its output register while the receiver pops, in encode and decode
// alike; padding and check bytes are each issued as a result of their own.
// Input and output are parted by a four-entry job queue and a two-bank byte
// store; full rises when the queue is full or, in decode, when the bank to be
// filled is still draining. A stalled receiver holds the output register and
// backs the queue up. Reset selects encode, sets the limit to all ones and
// empties every queue.
`timescale 1ns / 1ps

module secded_hamming_128_120_byte_codec import hsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 push,
  input  hsc_in_t              in_item_i,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output hsc_out_t             out_item_o
);

  job_t     job_in, job_head;
  logic     job_push, job_full, job_empty, job_pop;
  mem_wr_t  mem_wr;
  release_t bank_release;

  hsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_push_i  (push),
    .in_item_i  (in_item_i),
    .in_full_o  (full),
    .job_full_i (job_full),
    .job_o      (job_in),
    .job_push_o (job_push),
    .mem_wr_o   (mem_wr),
    .release_i  (bank_release)
  );

  hsc_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty)
  );

  hsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_wr_i    (mem_wr),
    .job_i       (job_head),
    .job_valid_i (!job_empty),
    .job_pop_o   (job_pop),
    .release_o   (bank_release),
    .out_item_o  (out_item_o),
    .out_empty_o (empty),
    .out_pop_i   (pop)
  );

`ifndef SYNTH
  a_check_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.is_check_byte) |->
      (out_item_o.last && out_item_o.error_status == ST_CLEAN))
    else $error("check byte not closing its block");

  a_position_only_corrected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.error_status != ST_CORRECTED) |->
      (out_item_o.error_position == '0))
    else $error("error position set without a correction");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  a_release_with_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_release.valid |-> (job_pop && !job_empty))
    else $error("bank released without finishing its job");
`endif

endmodule

[design/hsc_front.sv]
// Front end: takes input bytes, tracks syndrome and parity, classifies blocks.
`timescale 1ns / 1ps

module hsc_front import hsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  input  logic                 in_push_i,
  input  hsc_in_t              in_item_i,
  output logic                 in_full_o,
  input  logic                 job_full_i,
  output job_t                 job_o,
  output logic                 job_push_o,
  output mem_wr_t              mem_wr_o,
  input  release_t             release_i
);

  logic              dir_q, dir_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  syn_q, syn_d;
  logic              par_q, par_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [LEN_W-1:0]  emitted_q, emitted_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;

  logic [SLOT_W-1:0] slot_cur;
  logic              dec_check;
  logic              enc_check;
  logic              accept;
  logic [POS_W-1:0]  syn_abs;
  logic              par_abs;
  logic [7:0]        check_byte;
  logic [POS_W-1:0]  syn_blk;
  logic              par_blk;
  err_status_e       status;
  logic              flip_valid;
  logic [POS_W-1:0]  flip_index;
  logic [LEN_W-1:0]  remaining;
  logic [SLOT_W-1:0] emit_n;
  logic [LEN_W-1:0]  emitted_next;

  // Codeword position of data bit d: skip position zero and the check positions.
  function automatic logic [POS_W-1:0] pos_of(input logic [POS_W-1:0] d);
    logic [POS_W:0] p;
    p = {1'b0, d} + (POS_W+1)'(3);
    for (int i = 0; i < 5; i++) begin
      if (p >= (POS_W+1)'(4 << i)) begin
        p = p + (POS_W+1)'(1);
      end
    end
    return p[POS_W-1:0];
  endfunction

  // Data bit index of a syndrome that names a data position.
  function automatic logic [POS_W-1:0] data_index_of(input logic [POS_W-1:0] s);
    logic [POS_W-1:0] d;
    d = s - POS_W'(3);
    for (int i = 0; i < 5; i++) begin
      if (POS_W'(4 << i) < s) begin
        d = d - POS_W'(1);
      end
    end
    return d;
  endfunction

  assign slot_cur  = (!dir_q && slot_q == CHECK_SLOT) ? '0 : slot_q;
  assign dec_check = dir_q && (slot_cur == CHECK_SLOT);
  assign enc_check = in_item_i.end_of_stream || (slot_cur == LAST_DATA_SLOT);

  assign in_full_o = job_full_i || (dir_q && !dec_check && busy_q[bank_q]);
  assign accept    = in_push_i && !in_full_o;

  always_comb begin
    syn_abs = syn_q;
    for (int b = 0; b < 8; b++) begin
      if (in_item_i.data_in[b]) begin
        syn_abs = syn_abs ^ pos_of({slot_cur, 3'(b)});
      end
    end
  end

  assign par_abs    = par_q ^ (^in_item_i.data_in);
  assign check_byte = {par_abs ^ (^syn_abs), syn_abs};

  assign syn_blk = syn_q ^ in_item_i.data_in[POS_W-1:0];
  assign par_blk = par_q ^ (^in_item_i.data_in);

  always_comb begin
    status     = ST_CLEAN;
    flip_valid = 1'b0;
    if (syn_blk == '0) begin
      status = par_blk ? ST_PARITY : ST_CLEAN;
    end else if (par_blk) begin
      status     = ST_CORRECTED;
      // A single error on a check position leaves the data alone.
      flip_valid = ((syn_blk & (syn_blk - POS_W'(1))) != '0) && (syn_blk >= POS_W'(3));
    end else begin
      status = ST_DOUBLE;
    end
  end

  assign flip_index = data_index_of(syn_blk);

  // Bytes still under the limit before this block; at most 15 of them go out.
  assign remaining = len_q - emitted_q;
  always_comb begin
    if (emitted_q >= len_q) begin
      emit_n       = '0;
      emitted_next = emitted_q;
    end else if (remaining >= LEN_W'(BLOCK_BYTES)) begin
      emit_n       = SLOT_W'(BLOCK_BYTES);
      emitted_next = emitted_q + LEN_W'(BLOCK_BYTES);
    end else begin
      emit_n       = remaining[SLOT_W-1:0];
      emitted_next = len_q;
    end
  end

  always_comb begin
    dir_d      = dir_q;
    len_d      = len_q;
    syn_d      = syn_q;
    par_d      = par_q;
    slot_d     = slot_q;
    emitted_d  = emitted_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    job_o      = '0;
    job_push_o = 1'b0;
    mem_wr_o   = '0;

    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end

    if (accept) begin
      if (!dir_q) begin
        job_o.kind      = JOB_ENC;
        job_o.data      = in_item_i.data_in;
        job_o.pad_cnt   = in_item_i.end_of_stream ? (LAST_DATA_SLOT - slot_cur) : '0;
        job_o.has_check = enc_check;
        job_o.check     = check_byte;
        job_push_o      = 1'b1;
        if (enc_check) begin
          syn_d  = '0;
          par_d  = 1'b0;
          slot_d = '0;
        end else begin
          syn_d  = syn_abs;
          par_d  = par_abs;
          slot_d = slot_cur + SLOT_W'(1);
        end
      end else if (!dec_check) begin
        mem_wr_o = '{en: 1'b1, bank: bank_q, idx: slot_cur, data: in_item_i.data_in};
        if (in_item_i.end_of_stream) begin
          // Drop the partial block.
          syn_d  = '0;
          par_d  = 1'b0;
          slot_d = '0;
        end else begin
          syn_d  = syn_abs;
          par_d  = par_abs;
          slot_d = slot_cur + SLOT_W'(1);
        end
      end else begin
        job_o.kind       = JOB_DEC;
        job_o.bank       = bank_q;
        job_o.emit_cnt   = emit_n;
        job_o.status     = status;
        job_o.position   = (status == ST_CORRECTED) ? syn_blk : '0;
        job_o.flip_valid = flip_valid;
        job_o.flip_byte  = flip_index[POS_W-1:3];
        job_o.flip_mask  = 8'b1 << flip_index[2:0];
        if (emit_n != '0) begin
          job_push_o     = 1'b1;
          busy_d[bank_q] = 1'b1;
          bank_d         = ~bank_q;
        end
        emitted_d = emitted_next;
        syn_d     = '0;
        par_d     = 1'b0;
        slot_d    = '0;
      end
      if (in_item_i.end_of_stream) begin
        emitted_d = '0;
      end
    end

    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DIRECTION: begin
          dir_d     = cfg_data_i[0];
          syn_d     = '0;
          par_d     = 1'b0;
          slot_d    = '0;
          emitted_d = '0;
        end
        REG_DECODE_LENGTH: begin
          len_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      len_q     <= '1;
      syn_q     <= '0;
      par_q     <= 1'b0;
      slot_q    <= '0;
      emitted_q <= '0;
      bank_q    <= 1'b0;
      busy_q    <= '0;
    end else begin
      dir_q     <= dir_d;
      len_q     <= len_d;
      syn_q     <= syn_d;
      par_q     <= par_d;
      slot_q    <= slot_d;
      emitted_q <= emitted_d;
      bank_q    <= bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

[design/hsc_job_fifo.sv]
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module hsc_job_fifo import hsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_PTR_W:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (JOB_PTR_W+1)'(JOB_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (JOB_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (JOB_PTR_W+1)'(1);
      end
    end
  end

endmodule

[design/hsc_back.sv]
// Back end: byte store and result sequencer feeding the output register.
`timescale 1ns / 1ps

module hsc_back import hsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_wr_t  mem_wr_i,
  input  job_t     job_i,
  input  logic     job_valid_i,
  output logic     job_pop_o,
  output release_t release_o,
  output hsc_out_t out_item_o,
  output logic     out_empty_o,
  input  logic     out_pop_i
);

  logic [7:0]        held_q [2][BLOCK_BYTES];
  logic [SLOT_W-1:0] step_q;
  logic              out_valid_q;
  hsc_out_t          out_q;

  logic [SLOT_W:0]   n_results;
  logic              final_step;
  logic              load;
  hsc_out_t          res;
  logic [7:0]        dec_byte;

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      held_q[mem_wr_i.bank][mem_wr_i.idx] <= mem_wr_i.data;
    end
  end

  assign n_results = (job_i.kind == JOB_ENC)
                   ? ((SLOT_W+1)'(1) + {1'b0, job_i.pad_cnt} + (SLOT_W+1)'(job_i.has_check))
                   : {1'b0, job_i.emit_cnt};
  assign final_step = ({1'b0, step_q} == n_results - (SLOT_W+1)'(1));

  // Apply the single-bit correction on the way out.
  assign dec_byte = held_q[job_i.bank][step_q]
                  ^ ((job_i.flip_valid && job_i.flip_byte == step_q) ? job_i.flip_mask : '0);

  always_comb begin
    res = '0;
    res.last = final_step;
    if (job_i.kind == JOB_ENC) begin
      if (step_q == '0) begin
        res.data_out = job_i.data;
      end else if (step_q <= job_i.pad_cnt) begin
        res.data_out = '0;
      end else begin
        res.data_out      = job_i.check;
        res.is_check_byte = 1'b1;
      end
    end else begin
      res.data_out       = dec_byte;
      res.error_status   = job_i.status;
      res.error_position = job_i.position;
    end
  end

  assign load       = job_valid_i && (!out_valid_q || out_pop_i);
  assign job_pop_o  = load && final_step;
  assign release_o  = '{valid: load && final_step && (job_i.kind == JOB_DEC),
                        bank: job_i.bank};
  assign out_item_o = out_q;
  assign out_empty_o = !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= final_step ? '0 : step_q + SLOT_W'(1);
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
